// ===== rtl/rcp_pkg.sv =====
package rcp_pkg;

  // Field widths
  localparam int POS_W  = 18;
  localparam int CELL_W = 10;
  localparam int WT_W   = 3;
  localparam int ANG_W  = 17;
  localparam int RGB_W  = 24;
  localparam int FOV_W  = 16;
  localparam int SCR_W  = 16;

  // Internal widths
  localparam int DX_W   = 19;          // 2*|cell - player|, Q.8
  localparam int SQ_W   = 2 * DX_W + 1; // dx^2 + dy^2
  localparam int ROOT_W = (SQ_W + 1) / 2;
  localparam int DIFF_W = ANG_W + 1;   // ray - view
  localparam int CMAG_W = 16;          // |cos| in Q1.15, up to 1.0
  localparam int CORR_W = ROOT_W;

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = RGB_W;

  localparam logic [CFG_IDX_W-1:0] REG_COLOR_NORTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_EAST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_SOUTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_WEST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FOV         = 3'd4;

  localparam logic [RGB_W-1:0] COLOR_NORTH_RST = 24'hFF0000;
  localparam logic [RGB_W-1:0] COLOR_EAST_RST  = 24'h00FF00;
  localparam logic [RGB_W-1:0] COLOR_SOUTH_RST = 24'hFFA500;
  localparam logic [RGB_W-1:0] COLOR_WEST_RST  = 24'h0000FF;
  localparam logic [FOV_W-1:0] FOV_RST         = 16'd10923;

  // Wall side codes
  localparam logic [WT_W-1:0] WALL_NORTH = 3'd1;
  localparam logic [WT_W-1:0] WALL_EAST  = 3'd2;
  localparam logic [WT_W-1:0] WALL_SOUTH = 3'd3;

  // Cosine polynomial, Q28
  localparam logic [17:0] COS_C4  = 18'd246762;
  localparam logic [22:0] COS_C3  = 23'd5600498;
  localparam logic [26:0] COS_C2  = 27'd68093891;
  localparam logic [28:0] COS_C1  = 29'd331168970;
  localparam logic [28:0] ONE_Q28 = 29'd268435456;

  // Default screen geometry
  localparam int SCREEN_HEIGHT_DEF = 512;
  localparam int SCREEN_WIDTH_DEF  = 1024;
  localparam int RAY_COUNT_DEF     = 1024;

  // Divider step
  localparam int DIV_STEP = 2;

endpackage

// ===== rtl/rcp_if.sv =====
interface rcp_in_if import rcp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  player_x;
  logic [POS_W-1:0]  player_y;
  logic [CELL_W-1:0] hit_x;
  logic [CELL_W-1:0] hit_y;
  logic [WT_W-1:0]   wall_type;
  logic signed [ANG_W-1:0] ray_angle;
  logic signed [ANG_W-1:0] view_angle;

  modport source (output valid, player_x, player_y, hit_x, hit_y, wall_type,
                  ray_angle, view_angle, input ready);
  modport sink (input valid, player_x, player_y, hit_x, hit_y, wall_type,
                ray_angle, view_angle, output ready);
endinterface

interface rcp_out_if import rcp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SCR_W-1:0] screen_column;
  logic signed [SCR_W-1:0] top_row;
  logic [SCR_W-1:0]        span_height;
  logic [RGB_W-1:0]        color;
  logic                    distance_zero;

  modport source (output valid, screen_column, top_row, span_height, color,
                  distance_zero, input ready);
  modport sink (input valid, screen_column, top_row, span_height, color,
                distance_zero, output ready);
endinterface

// ===== rtl/rcp_cos.sv =====
// Cosine of a 16-bit full-turn phase, magnitude in Q1.15 plus sign.
// Six stages; each stage after the first does one multiply.
module rcp_cos import rcp_pkg::*; #(
  parameter int TAG_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              i_vld,
  input  logic [15:0]       i_phase,
  input  logic [TAG_W-1:0]  i_tag,
  output logic              o_vld,
  output logic [CMAG_W-1:0] o_cmag,
  output logic              o_neg,
  output logic [TAG_W-1:0]  o_tag
);

  localparam int NS = 6;

  logic [NS-1:0]    vld_r;
  logic [NS-1:0]    neg_r;
  logic [TAG_W-1:0] tag_r [NS];

  logic [14:0] t_r;
  logic [28:0] u1_r, u2_r, u3_r, u4_r;
  logic [22:0] p1_r;
  logic [26:0] p2_r;
  logic [28:0] p3_r;
  logic [CMAG_W-1:0] c_r;

  logic [14:0] t_nxt;
  logic [46:0] m1;
  logic [51:0] m2;
  logic [55:0] m3;
  logic [57:0] m4;
  logic [28:0] q4;

  always_comb begin
    // odd quadrants mirror the phase
    t_nxt = i_phase[14] ? 15'(15'd16384 - {1'b0, i_phase[13:0]}) : {1'b0, i_phase[13:0]};
    m1 = 47'(COS_C4) * 47'(u1_r);
    m2 = 52'(p1_r) * 52'(u2_r);
    m3 = 56'(p2_r) * 56'(u3_r);
    m4 = 58'(p3_r) * 58'(u4_r);
    q4 = m4[56:28];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], i_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r    <= {neg_r[NS-2:0], i_phase[15] ^ i_phase[14]};
      tag_r[0] <= i_tag;
      for (int s = 1; s < NS; s++) tag_r[s] <= tag_r[s-1];
      t_r  <= t_nxt;
      u1_r <= 29'(t_r) * 29'(t_r);
      u2_r <= u1_r;
      p1_r <= COS_C3 - 23'(m1[46:28]);
      u3_r <= u2_r;
      p2_r <= COS_C2 - 27'(m2[51:28]);
      u4_r <= u3_r;
      p3_r <= COS_C1 - 29'(m3[55:28]);
      if (q4 >= ONE_Q28) begin
        c_r <= '0;
      end else begin
        c_r <= CMAG_W'((ONE_Q28 - q4) >> 13);
      end
    end
  end

  assign o_vld  = vld_r[NS-1];
  assign o_neg  = neg_r[NS-1];
  assign o_cmag = c_r;
  assign o_tag  = tag_r[NS-1];

endmodule

// ===== rtl/rcp_sqrt.sv =====
// Floor square root, one result bit per stage.
module rcp_sqrt import rcp_pkg::*; #(
  parameter int IN_W  = SQ_W,
  parameter int TAG_W = 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      i_vld,
  input  logic [IN_W-1:0]           i_rad,
  input  logic [TAG_W-1:0]          i_tag,
  output logic                      o_vld,
  output logic [(IN_W+1)/2-1:0]     o_root,
  output logic [TAG_W-1:0]          o_tag
);

  localparam int RW    = (IN_W + 1) / 2;
  localparam int PW    = 2 * RW;
  localparam int REM_W = RW + 3;

  logic             p_vld  [RW+1];
  logic [REM_W-1:0] p_rem  [RW+1];
  logic [RW-1:0]    p_root [RW+1];
  logic [PW-1:0]    p_rad  [RW+1];
  logic [TAG_W-1:0] p_tag  [RW+1];

  assign p_vld[0]  = i_vld;
  assign p_rem[0]  = '0;
  assign p_root[0] = '0;
  assign p_rad[0]  = PW'(i_rad);
  assign p_tag[0]  = i_tag;

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic             vld_r;
    logic [REM_W-1:0] rem_r, rem_nxt, rem_sh, trial;
    logic [RW-1:0]    root_r, root_nxt;
    logic [PW-1:0]    rad_r;
    logic [TAG_W-1:0] tag_r;

    always_comb begin
      rem_sh = {p_rem[s][REM_W-3:0], p_rad[s][PW-1:PW-2]};
      trial  = REM_W'({p_root[s], 2'b01});
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {p_root[s][RW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {p_root[s][RW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= p_vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        rad_r  <= p_rad[s] << 2;
        tag_r  <= p_tag[s];
      end
    end

    assign p_vld[s+1]  = vld_r;
    assign p_rem[s+1]  = rem_r;
    assign p_root[s+1] = root_r;
    assign p_rad[s+1]  = rad_r;
    assign p_tag[s+1]  = tag_r;
  end

  assign o_vld  = p_vld[RW];
  assign o_root = p_root[RW];
  assign o_tag  = p_tag[RW];

endmodule

// ===== rtl/rcp_div.sv =====
// Unsigned restoring divider, STEP quotient bits per stage.
module rcp_div import rcp_pkg::*; #(
  parameter int NW    = 26,
  parameter int DW    = 20,
  parameter int STEP  = DIV_STEP,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             i_vld,
  input  logic [NW-1:0]    i_num,
  input  logic [DW-1:0]    i_den,
  input  logic [TAG_W-1:0] i_tag,
  output logic             o_vld,
  output logic [NW-1:0]    o_quo,
  output logic [TAG_W-1:0] o_tag
);

  localparam int NS = (NW + STEP - 1) / STEP;
  localparam int PW = NS * STEP;

  logic             p_vld [NS+1];
  logic [DW-1:0]    p_rem [NS+1];
  logic [DW-1:0]    p_den [NS+1];
  logic [PW-1:0]    p_num [NS+1];
  logic [PW-1:0]    p_quo [NS+1];
  logic [TAG_W-1:0] p_tag [NS+1];

  assign p_vld[0] = i_vld;
  assign p_rem[0] = '0;
  assign p_den[0] = i_den;
  assign p_num[0] = PW'(i_num);
  assign p_quo[0] = '0;
  assign p_tag[0] = i_tag;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic             vld_r;
    logic [DW-1:0]    rem_r, den_r, rem_v;
    logic [PW-1:0]    num_r, quo_r, num_v, quo_v;
    logic [TAG_W-1:0] tag_r;
    logic [DW:0]      remx;

    always_comb begin
      rem_v = p_rem[s];
      num_v = p_num[s];
      quo_v = p_quo[s];
      remx  = '0;
      for (int j = 0; j < STEP; j++) begin
        remx  = {rem_v, num_v[PW-1]};
        num_v = num_v << 1;
        if (remx >= {1'b0, p_den[s]}) begin
          rem_v = DW'(remx - {1'b0, p_den[s]});
          quo_v = {quo_v[PW-2:0], 1'b1};
        end else begin
          rem_v = remx[DW-1:0];
          quo_v = {quo_v[PW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= p_vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r <= rem_v;
        num_r <= num_v;
        quo_r <= quo_v;
        den_r <= p_den[s];
        tag_r <= p_tag[s];
      end
    end

    assign p_vld[s+1] = vld_r;
    assign p_rem[s+1] = rem_r;
    assign p_den[s+1] = den_r;
    assign p_num[s+1] = num_r;
    assign p_quo[s+1] = quo_r;
    assign p_tag[s+1] = tag_r;
  end

  assign o_vld = p_vld[NS];
  assign o_quo = p_quo[NS][NW-1:0];
  assign o_tag = p_tag[NS];

endmodule

// ===== rtl/raycast_wall_column_projector_top.sv =====
// Raycast wall column projector.
// in_ch takes one ray hit per request (player position, hit cell, wall side,
// ray and view angle); out_ch returns one wall span per request: screen
// column, top row, height, color and a zero-distance flag. Results come out
// in request order, exactly one per hit.
// Throughput: one request per cycle, no bubbles, while out_ch accepts spans.
// The sqrt (one bit per stage) and the two dividers (two quotient bits per
// stage) set the pipeline depth.
// Stall: the whole pipe advances together; while the output register holds
// an unaccepted span, in_ch.ready is low and every stage holds.
// Reset (rst_n low, synchronous): all valid bits clear, colors and field of
// view return to their defaults. The user must write configuration through
// cfg_we/cfg_index/cfg_data only while the pipe is empty; the block does not
// enforce this. Unknown indexes are dropped; a zero field of view acts as one.
module raycast_wall_column_projector_top import rcp_pkg::*; #(
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int RAY_COUNT     = RAY_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  rcp_in_if.sink               in_ch,
  rcp_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // height numerator 32*H in Q.8
  localparam longint HNUM   = 64'(8192) * SCREEN_HEIGHT;
  localparam int     HNUM_W = $clog2(HNUM + 1);
  // worst-case column numerator magnitude
  localparam longint COL_MAX = 64'(SCREEN_WIDTH / 2) * 65535 + 64'(131071) * (RAY_COUNT - 1);
  localparam int     COL_W   = $clog2(COL_MAX + 1);
  localparam int     NUMC_W  = COL_W + 1;

  localparam logic signed [NUMC_W-1:0] HALF_W_S  = NUMC_W'(SCREEN_WIDTH / 2);
  localparam logic signed [NUMC_W-1:0] RAYS_M1_S = NUMC_W'(RAY_COUNT - 1);
  localparam logic signed [SCR_W-1:0]  HALF_H_S  = SCR_W'(SCREEN_HEIGHT / 2);
  localparam logic [HNUM_W-1:0]        HNUM_C    = HNUM_W'(HNUM);

  typedef struct packed {
    logic [DX_W-1:0]          ax;
    logic [DX_W-1:0]          ay;
    logic signed [DIFF_W-1:0] diff;
    logic [RGB_W-1:0]         color;
  } cos_tag_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] diff;
    logic [RGB_W-1:0]         color;
    logic [CMAG_W-1:0]        cmag;
    logic                     cneg;
  } sq_tag_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] diff;
    logic [RGB_W-1:0]         color;
    logic                     zflag;
  } hd_tag_t;

  typedef struct packed {
    logic [SCR_W-1:0]        height;
    logic signed [SCR_W-1:0] top;
    logic [RGB_W-1:0]        color;
    logic                    zflag;
    logic                    neg;
  } cd_tag_t;

  // ---------------- configuration registers
  logic [RGB_W-1:0] col_n_r, col_e_r, col_s_r, col_w_r;
  logic [FOV_W-1:0] fov_r, fov_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_n_r <= COLOR_NORTH_RST;
      col_e_r <= COLOR_EAST_RST;
      col_s_r <= COLOR_SOUTH_RST;
      col_w_r <= COLOR_WEST_RST;
      fov_r   <= FOV_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COLOR_NORTH: col_n_r <= cfg_data;
        REG_COLOR_EAST:  col_e_r <= cfg_data;
        REG_COLOR_SOUTH: col_s_r <= cfg_data;
        REG_COLOR_WEST:  col_w_r <= cfg_data;
        REG_FOV:         fov_r   <= cfg_data[FOV_W-1:0];
        default: ;
      endcase
    end
  end

  assign fov_eff = (fov_r == '0) ? FOV_W'(1) : fov_r;

  // ---------------- global advance: freeze only when the output is stuck
  logic out_vld_r;
  logic en;

  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // ---------------- stage 0: deltas, angle difference, color pick
  logic [DX_W-1:0]     ex, ey;
  logic [DX_W-2:0]     ax_m, ay_m;
  logic [RGB_W-1:0]    color_sel;
  logic                s0_vld_r;
  cos_tag_t            s0_r;

  always_comb begin
    ex   = {1'b0, in_ch.hit_x, 8'b0} - {1'b0, in_ch.player_x};
    ey   = {1'b0, in_ch.hit_y, 8'b0} - {1'b0, in_ch.player_y};
    ax_m = ex[DX_W-1] ? (DX_W-1)'(-ex) : ex[DX_W-2:0];
    ay_m = ey[DX_W-1] ? (DX_W-1)'(-ey) : ey[DX_W-2:0];
    unique case (in_ch.wall_type)
      WALL_NORTH: color_sel = col_n_r;
      WALL_EAST:  color_sel = col_e_r;
      WALL_SOUTH: color_sel = col_s_r;
      default:    color_sel = col_w_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r.ax    <= {ax_m, 1'b0};
      s0_r.ay    <= {ay_m, 1'b0};
      s0_r.diff  <= {in_ch.ray_angle[ANG_W-1], in_ch.ray_angle}
                  - {in_ch.view_angle[ANG_W-1], in_ch.view_angle};
      s0_r.color <= color_sel;
    end
  end

  // ---------------- cosine of ray-to-view angle
  logic              cos_vld;
  logic [CMAG_W-1:0] cos_mag;
  logic              cos_neg;
  cos_tag_t          cos_tag;

  rcp_cos #(.TAG_W($bits(cos_tag_t))) u_cos (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .i_vld   (s0_vld_r),
    .i_phase (s0_r.diff[15:0]),
    .i_tag   (s0_r),
    .o_vld   (cos_vld),
    .o_cmag  (cos_mag),
    .o_neg   (cos_neg),
    .o_tag   (cos_tag)
  );

  // ---------------- stages 1-2: squares and their sum
  logic                s1_vld_r, s2_vld_r;
  logic [2*DX_W-1:0]   sqx_r, sqy_r;
  logic [SQ_W-1:0]     sum_r;
  sq_tag_t             s1_tag_r, s2_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= cos_vld;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r          <= (2*DX_W)'(cos_tag.ax) * (2*DX_W)'(cos_tag.ax);
      sqy_r          <= (2*DX_W)'(cos_tag.ay) * (2*DX_W)'(cos_tag.ay);
      s1_tag_r.diff  <= cos_tag.diff;
      s1_tag_r.color <= cos_tag.color;
      s1_tag_r.cmag  <= cos_mag;
      s1_tag_r.cneg  <= cos_neg;
      sum_r          <= SQ_W'(sqx_r) + SQ_W'(sqy_r);
      s2_tag_r       <= s1_tag_r;
    end
  end

  // ---------------- distance
  logic              sq_vld;
  logic [ROOT_W-1:0] root;
  sq_tag_t           sq_tag;

  rcp_sqrt #(.IN_W(SQ_W), .TAG_W($bits(sq_tag_t))) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .i_vld  (s2_vld_r),
    .i_rad  (sum_r),
    .i_tag  (s2_tag_r),
    .o_vld  (sq_vld),
    .o_root (root),
    .o_tag  (sq_tag)
  );

  // ---------------- stage 3: fisheye correction
  logic [ROOT_W+CMAG_W-1:0] prod;
  logic [CORR_W-1:0]        corr;
  logic                     s3_vld_r;
  logic [CORR_W-1:0]        corr_r;
  hd_tag_t                  s3_tag_r;

  always_comb begin
    prod = (ROOT_W+CMAG_W)'(root) * (ROOT_W+CMAG_W)'(sq_tag.cmag);
    // product is only positive for a positive cosine
    corr = (!sq_tag.cneg) ? prod[CORR_W+14:15] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      corr_r         <= corr;
      s3_tag_r.diff  <= sq_tag.diff;
      s3_tag_r.color <= sq_tag.color;
      s3_tag_r.zflag <= (corr == '0);
    end
  end

  // ---------------- slice height
  logic              hd_vld;
  logic [HNUM_W-1:0] hquo;
  hd_tag_t           hd_tag;

  rcp_div #(.NW(HNUM_W), .DW(CORR_W), .STEP(DIV_STEP), .TAG_W($bits(hd_tag_t))) u_hdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .i_vld (s3_vld_r),
    .i_num (HNUM_C),
    .i_den (corr_r),
    .i_tag (s3_tag_r),
    .o_vld (hd_vld),
    .o_quo (hquo),
    .o_tag (hd_tag)
  );

  // ---------------- stage 5: height, top row, column numerator
  logic [SCR_W-1:0]         height;
  logic signed [NUMC_W-1:0] numc;
  logic                     s5_vld_r;
  logic signed [NUMC_W-1:0] numc_r;
  cd_tag_t                  s5_tag_r;

  always_comb begin
    if (hd_tag.zflag || (hquo[HNUM_W-1:SCR_W] != '0)) begin
      height = '1;
    end else begin
      height = hquo[SCR_W-1:0];
    end
    numc = signed'(NUMC_W'(fov_eff)) * HALF_W_S + NUMC_W'(hd_tag.diff) * RAYS_M1_S;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s5_vld_r <= hd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      numc_r          <= numc;
      s5_tag_r.height <= height;
      s5_tag_r.top    <= HALF_H_S - signed'(SCR_W'(height >> 1));
      s5_tag_r.color  <= hd_tag.color;
      s5_tag_r.zflag  <= hd_tag.zflag;
      s5_tag_r.neg    <= numc[NUMC_W-1];
    end
  end

  // ---------------- screen column, divided toward zero by magnitude
  logic [COL_W-1:0] cnum_mag;
  logic             cd_vld;
  logic [COL_W-1:0] cquo;
  cd_tag_t          cd_tag;

  assign cnum_mag = numc_r[NUMC_W-1] ? COL_W'(-numc_r) : numc_r[COL_W-1:0];

  rcp_div #(.NW(COL_W), .DW(FOV_W), .STEP(DIV_STEP), .TAG_W($bits(cd_tag_t))) u_cdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .i_vld (s5_vld_r),
    .i_num (cnum_mag),
    .i_den (fov_eff),
    .i_tag (s5_tag_r),
    .o_vld (cd_vld),
    .o_quo (cquo),
    .o_tag (cd_tag)
  );

  // ---------------- output register with column saturation
  logic signed [SCR_W-1:0] col_sat;
  logic signed [SCR_W-1:0] out_col_r, out_top_r;
  logic [SCR_W-1:0]        out_h_r;
  logic [RGB_W-1:0]        out_clr_r;
  logic                    out_dz_r;

  always_comb begin
    if (cd_tag.neg) begin
      col_sat = (cquo > COL_W'(32768)) ? 16'sh8000 : signed'(SCR_W'(~cquo[SCR_W-1:0] + 1'b1));
    end else begin
      col_sat = (cquo > COL_W'(32767)) ? 16'sh7FFF : signed'(cquo[SCR_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= cd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_col_r <= col_sat;
      out_top_r <= cd_tag.top;
      out_h_r   <= cd_tag.height;
      out_clr_r <= cd_tag.color;
      out_dz_r  <= cd_tag.zflag;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.screen_column = out_col_r;
  assign out_ch.top_row       = out_top_r;
  assign out_ch.span_height   = out_h_r;
  assign out_ch.color         = out_clr_r;
  assign out_ch.distance_zero = out_dz_r;

  // ---------------- assertions
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> s0_vld_r)
    else $error("accepted request did not enter stage 0");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while output stalled");

  a_zero_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_dz_r |-> out_h_r == '1)
    else $error("zero distance without saturated height");

  a_top_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_top_r == HALF_H_S - signed'(SCR_W'(out_h_r >> 1)))
    else $error("top row inconsistent with height");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");

endmodule

// ===== bench/tb_rcp_checker.sv =====
`timescale 1ns / 100ps
module tb_rcp_checker import rcp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  rcp_in_if.sink               in_mon,
  rcp_out_if.sink              out_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   spans_pending
);

  typedef struct packed {
    logic signed [SCR_W-1:0] screen_column;
    logic signed [SCR_W-1:0] top_row;
    logic [SCR_W-1:0]        span_height;
    logic [RGB_W-1:0]        color;
    logic                    distance_zero;
  } span_t;

  span_t span_q[$];
  logic [RGB_W-1:0] col_n, col_e, col_s, col_w;
  logic [FOV_W-1:0] fov_reg;

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Q1.15 cosine of a 16-bit full-turn phase
  function automatic longint cosine_q15(logic [15:0] ph);
    logic [1:0] quad;
    longint t, u, p, c;
    quad = ph[15:14];
    t = (quad == 2'd1 || quad == 2'd3) ? 16384 - longint'(ph[13:0]) : longint'(ph[13:0]);
    u = t * t;
    p = longint'(COS_C4);
    p = longint'(COS_C3) - ((p * u) >>> 28);
    p = longint'(COS_C2) - ((p * u) >>> 28);
    p = longint'(COS_C1) - ((p * u) >>> 28);
    p = longint'(ONE_Q28) - ((p * u) / longint'(ONE_Q28));
    if (p < 0) p = 0;
    if (p > longint'(ONE_Q28)) p = longint'(ONE_Q28);
    c = p >>> 13;
    return (quad == 2'd1 || quad == 2'd2) ? -c : c;
  endfunction

  function automatic span_t project_span(
      logic [POS_W-1:0] px, logic [POS_W-1:0] py, logic [CELL_W-1:0] hx,
      logic [CELL_W-1:0] hy, logic [WT_W-1:0] wt,
      logic signed [ANG_W-1:0] ray, logic signed [ANG_W-1:0] view);
    span_t s;
    longint dx, dy, dlen, diff, cs, prod, corr, h, top, col, fv, num;
    dx = 2 * (longint'(hx) * 256 - longint'(px));
    dy = 2 * (longint'(hy) * 256 - longint'(py));
    dlen = longint'(root64(dx * dx + dy * dy));
    diff = longint'(ray) - longint'(view);
    cs = cosine_q15(diff[15:0]);
    prod = dlen * cs;
    corr = prod > 0 ? (prod >>> 15) : 0;
    if (corr <= 0) begin
      s.distance_zero = 1'b1;
      h = 65535;
    end else begin
      s.distance_zero = 1'b0;
      h = (longint'(32) * SCREEN_HEIGHT_DEF * 256) / corr;
      if (h > 65535) h = 65535;
    end
    top = SCREEN_HEIGHT_DEF / 2 - (h >>> 1);
    fv = longint'(fov_reg);
    if (fv == 0) fv = 1;
    num = longint'(SCREEN_WIDTH_DEF / 2) * fv + diff * longint'(RAY_COUNT_DEF - 1);
    col = num / fv;
    if (col > 32767) col = 32767;
    if (col < -32768) col = -32768;
    unique case (wt)
      WALL_NORTH: s.color = col_n;
      WALL_EAST:  s.color = col_e;
      WALL_SOUTH: s.color = col_s;
      default:    s.color = col_w;
    endcase
    s.screen_column = col[15:0];
    s.top_row = top[15:0];
    s.span_height = h[15:0];
    return s;
  endfunction

  assign spans_pending = span_q.size();

  always @(posedge clk) begin
    span_t got, want;
    if (!rst_n) begin
      col_n <= COLOR_NORTH_RST;
      col_e <= COLOR_EAST_RST;
      col_s <= COLOR_SOUTH_RST;
      col_w <= COLOR_WEST_RST;
      fov_reg <= FOV_RST;
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_COLOR_NORTH: col_n <= cfg_data;
          REG_COLOR_EAST:  col_e <= cfg_data;
          REG_COLOR_SOUTH: col_s <= cfg_data;
          REG_COLOR_WEST:  col_w <= cfg_data;
          REG_FOV:         fov_reg <= cfg_data[FOV_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        span_q.push_back(project_span(in_mon.player_x, in_mon.player_y, in_mon.hit_x,
            in_mon.hit_y, in_mon.wall_type, in_mon.ray_angle, in_mon.view_angle));
      if (out_mon.valid && out_mon.ready) begin
        got.screen_column = out_mon.screen_column;
        got.top_row = out_mon.top_row;
        got.span_height = out_mon.span_height;
        got.color = out_mon.color;
        got.distance_zero = out_mon.distance_zero;
        if (span_q.size() == 0) begin
          $error("unexpected span");
          fail_count <= fail_count + 1;
        end else begin
          want = span_q.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (got.screen_column !== want.screen_column)
              $error("screen_column exp %0d got %0d", want.screen_column, got.screen_column);
            if (got.top_row !== want.top_row)
              $error("top_row exp %0d got %0d", want.top_row, got.top_row);
            if (got.span_height !== want.span_height)
              $error("span_height exp %0d got %0d", want.span_height, got.span_height);
            if (got.color !== want.color)
              $error("color exp %h got %h", want.color, got.color);
            if (got.distance_zero !== want.distance_zero)
              $error("distance_zero exp %b got %b", want.distance_zero, got.distance_zero);
          end
        end
      end
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
  import rcp_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  int fail_count, spans_pending;
  int send_idle_pct = 14;   // chance in 100 that the sender skips a cycle
  int recv_idle_pct = 84;   // chance in 100 that the receiver stalls

  rcp_in_if  in_ch();
  rcp_out_if out_ch();

  always #1 clk = ~clk;

  raycast_wall_column_projector_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tb_rcp_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .spans_pending(spans_pending)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.player_x = '0;
    in_ch.player_y = '0;
    in_ch.hit_x = '0;
    in_ch.hit_y = '0;
    in_ch.wall_type = '0;
    in_ch.ray_angle = '0;
    in_ch.view_angle = '0;
    out_ch.ready = 1'b0;
  end

  // receiver: random backpressure at the current stall rate
  always @(posedge clk)
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

  // Send one request; holds valid across back-to-back requests.
  task automatic send_hit(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                          logic [CELL_W-1:0] hx, logic [CELL_W-1:0] hy,
                          logic [WT_W-1:0] wt, logic [ANG_W-1:0] ra,
                          logic [ANG_W-1:0] va);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.player_x <= px;
    in_ch.player_y <= py;
    in_ch.hit_x <= hx;
    in_ch.hit_y <= hy;
    in_ch.wall_type <= wt;
    in_ch.ray_angle <= ra;
    in_ch.view_angle <= va;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop valid, drain every pending span, then let the pipe settle.
  task automatic drain_pipe();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (spans_pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // one write, then cfg_we is dropped again before the next request or write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly realistic geometry: player near the hit, angles within the view,
  // with a share of fully random fields.
  task automatic send_random_hit();
    logic [POS_W-1:0] px, py;
    logic [CELL_W-1:0] hx, hy;
    logic [ANG_W-1:0] va, ra;
    px = POS_W'($urandom);
    py = POS_W'($urandom);
    va = ANG_W'($urandom);
    if ($urandom_range(3) != 0) begin
      hx = CELL_W'(px[17:8] + $urandom_range(16) - 8);
      hy = CELL_W'(py[17:8] + $urandom_range(16) - 8);
      ra = ANG_W'(va + $urandom_range(12000) - 6000);
    end else begin
      hx = CELL_W'($urandom);
      hy = CELL_W'($urandom);
      ra = ANG_W'($urandom);
    end
    send_hit(px, py, hx, hy, WT_W'($urandom), ra, va);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, each wall side, zero distance
    send_hit('0, '0, '0, '0, 3'd0, '0, '0);                  // player on the hit cell
    send_hit(18'h3FFFF, 18'h3FFFF, 10'h3FF, 10'h3FF, WALL_NORTH, 17'h0FFFF, 17'h10000);
    send_hit('0, '0, 10'h3FF, 10'h3FF, WALL_EAST, 17'h10000, 17'h0FFFF);
    send_hit(18'h3FFFF, '0, '0, 10'h3FF, WALL_SOUTH, 17'h04000, 17'h0);   // cos zero
    send_hit(18'h100, 18'h100, 10'd1, 10'd1, 3'd4, 17'h08000, 17'h0);
    send_hit(18'h0, 18'h0, 10'd1, 10'd0, 3'd7, 17'h0, 17'h0);      // tiny distance
    send_hit(18'h12345, 18'h2ABCD, 10'd500, 10'd20, 3'd5, 17'h1C000, 17'h04000);
    send_hit(18'h00080, 18'h00080, 10'd0, 10'd0, 3'd6, 17'h00010, 17'h1FFF0);
    drain_pipe();

    // extremes of configuration, including a zero field of view
    write_reg(REG_COLOR_NORTH, 24'h000000);
    write_reg(REG_COLOR_EAST, 24'hFFFFFF);
    write_reg(REG_COLOR_SOUTH, 24'h5A5A5A);
    write_reg(REG_COLOR_WEST, 24'hA5A5A5);
    write_reg(REG_FOV, 24'h000000);
    write_reg(3'd5, 24'h123456);          // unknown index, dropped
    for (int i = 0; i < 10; i++) send_random_hit();
    drain_pipe();
    write_reg(REG_FOV, 24'hFFFFFF);
    for (int i = 0; i < 10; i++) send_random_hit();
    drain_pipe();
    write_reg(REG_FOV, 24'd1);
    write_reg(3'd7, 24'hFFFFFF);
    for (int i = 0; i < 10; i++) send_random_hit();
    drain_pipe();

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 84;
        recv_idle_pct = 14;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(REG_COLOR_NORTH, CFG_W'($urandom));
      write_reg(REG_COLOR_EAST, CFG_W'($urandom));
      write_reg(REG_COLOR_SOUTH, CFG_W'($urandom));
      write_reg(REG_COLOR_WEST, CFG_W'($urandom));
      write_reg(REG_FOV, (phase == 2) ? 24'd10923 : CFG_W'($urandom_range(65535, 1)));
      for (int i = 0; i < 620; i++) begin
        send_random_hit();
        if (i == 300) drain_pipe();   // hold off until all spans are back
      end
      drain_pipe();
    end

    if (fail_count == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
